>>> rtl/core/rnp_pkg.sv
// Shared widths, codes, types and lookup functions of the RTTTL note parser.
package rnp_pkg;

  localparam int CHAR_W     = 8;
  localparam int DUR_W      = 7;
  localparam int DDUR_W     = 6;
  localparam int OCT_W      = 3;
  localparam int BEAT_W     = 10;
  localparam int NOTE_W     = 4;
  localparam int UNITS_W    = 6;
  localparam int UNIT_W     = 13;
  localparam int Q0_W       = 27;
  localparam int PERIOD_W   = 26;
  localparam int HIGH_W     = 25;
  localparam int LEN_W      = UNITS_W + UNIT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = BEAT_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_DUR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_OCT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAT    = 2'd2;

  localparam logic [DDUR_W-1:0] DEF_DUR_RESET = 6'd4;
  localparam logic [OCT_W-1:0]  DEF_OCT_RESET = 3'd6;
  localparam int                BEAT_RESET    = 63;
  localparam int                TEMPO_NUM     = 7500;
  localparam logic [UNIT_W-1:0] TEMPO_DVD     = UNIT_W'(TEMPO_NUM);
  localparam logic [UNIT_W-1:0] UNIT_RESET    = UNIT_W'(TEMPO_NUM / BEAT_RESET);

  // characters
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_4     = 8'h34;
  localparam logic [CHAR_W-1:0] CH_7     = 8'h37;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SHARP = 8'h23;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_G     = 8'h67;
  localparam logic [CHAR_W-1:0] CH_P     = 8'h70;

  // note codes
  localparam logic [NOTE_W-1:0] NOTE_REST = 4'd0;
  localparam logic [NOTE_W-1:0] NOTE_A    = 4'd1;
  localparam logic [NOTE_W-1:0] NOTE_B    = 4'd2;
  localparam logic [NOTE_W-1:0] NOTE_C    = 4'd3;
  localparam logic [NOTE_W-1:0] NOTE_D    = 4'd4;
  localparam logic [NOTE_W-1:0] NOTE_E    = 4'd5;
  localparam logic [NOTE_W-1:0] NOTE_F    = 4'd6;
  localparam logic [NOTE_W-1:0] NOTE_G    = 4'd7;
  localparam logic [NOTE_W-1:0] NOTE_AS   = 4'd8;
  localparam logic [NOTE_W-1:0] NOTE_CS   = 4'd9;
  localparam logic [NOTE_W-1:0] NOTE_DS   = 4'd10;
  localparam logic [NOTE_W-1:0] NOTE_FS   = 4'd11;
  localparam logic [NOTE_W-1:0] NOTE_GS   = 4'd12;

  // character class, datapath to controller
  typedef struct packed {
    logic is_digit;
    logic is_letter;
    logic is_sharp;
    logic is_oct;
    logic is_dot;
    logic is_comma;
    logic eot;
  } stat_t;

  // controller commands, valid only in the cycle a beat is taken, but for out_load, set whenever stage 1 advances
  typedef struct packed {
    logic s1_load;
    logic out_load;
    logic load_dig1;
    logic load_dig2;
    logic start_note;
    logic start_keep;
    logic sharpen;
    logic load_oct;
    logic set_dot;
    logic emit;
    logic emit_new;
    logic emit_end;
  } cmd_t;

  // floor(3.2e11 / base_tenths) at octave 0; shifting right by the octave
  // gives floor(3.2e11 / (base << oct)) exactly
  function automatic logic [Q0_W-1:0] note_q0(input logic [NOTE_W-1:0] note);
    logic [Q0_W-1:0] q;
    q = '0;
    case (note)
      NOTE_A:  q = 27'd72727272;
      NOTE_B:  q = 27'd64790443;
      NOTE_C:  q = 27'd122324159;
      NOTE_D:  q = 27'd108954715;
      NOTE_E:  q = 27'd97087378;
      NOTE_F:  q = 27'd91638029;
      NOTE_G:  q = 27'd81632653;
      NOTE_AS: q = 27'd68640068;
      NOTE_CS: q = 27'd115440115;
      NOTE_DS: q = 27'd102860816;
      NOTE_FS: q = 27'd86486486;
      NOTE_GS: q = 27'd77052732;
      default: q = '0;
    endcase
    return q;
  endfunction

  // thirty-second units in one note: floor(32 / d), 0 for d of 0 or above 32
  function automatic logic [UNITS_W-1:0] dur_units(input logic [DUR_W-1:0] d);
    logic [UNITS_W-1:0] n;
    if (d == 7'd0 || d > 7'd32) n = 6'd0;
    else if (d >= 7'd17)        n = 6'd1;
    else if (d >= 7'd11)        n = 6'd2;
    else if (d >= 7'd9)         n = 6'd3;
    else if (d >= 7'd7)         n = 6'd4;
    else if (d == 7'd6)         n = 6'd5;
    else if (d == 7'd5)         n = 6'd6;
    else if (d == 7'd4)         n = 6'd8;
    else if (d == 7'd3)         n = 6'd10;
    else if (d == 7'd2)         n = 6'd16;
    else                        n = 6'd32;
    return n;
  endfunction

  // sharp on b, e or rest leaves the note alone
  function automatic logic [NOTE_W-1:0] sharpen(input logic [NOTE_W-1:0] note);
    logic [NOTE_W-1:0] s;
    case (note)
      NOTE_A:  s = NOTE_AS;
      NOTE_C:  s = NOTE_CS;
      NOTE_D:  s = NOTE_DS;
      NOTE_F:  s = NOTE_FS;
      NOTE_G:  s = NOTE_GS;
      default: s = note;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/rnp_div.sv
// Tempo unit divider: 7500 / beat_value, one quotient bit per cycle.
module rnp_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [rnp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rnp_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  output logic                           busy,
  output logic [rnp_pkg::UNIT_W-1:0]     unit
);

  localparam int CNT_W = $clog2(rnp_pkg::UNIT_W);

  logic                          busy_r, busy_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [rnp_pkg::UNIT_W-1:0]    dvd_r, dvd_nxt;
  logic [rnp_pkg::BEAT_W-1:0]    rem_r, rem_nxt;
  logic [rnp_pkg::BEAT_W-1:0]    den_r, den_nxt;
  logic [rnp_pkg::UNIT_W-1:0]    unit_r, unit_nxt;
  logic [rnp_pkg::BEAT_W:0]      trial;
  logic                          qbit;
  logic                          start;

  assign start = cfg_wr_en && (cfg_index == rnp_pkg::CFG_BEAT);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    unit_nxt = unit_r;
    trial    = {rem_r, dvd_r[rnp_pkg::UNIT_W-1]};
    qbit     = (trial >= {1'b0, den_r});
    if (start) begin
      // beat of 0 counts as 1
      den_nxt  = (cfg_wr_data == '0) ? rnp_pkg::BEAT_W'(1) : cfg_wr_data;
      dvd_nxt  = rnp_pkg::TEMPO_DVD;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(rnp_pkg::UNIT_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits BEAT_W bits
      rem_nxt = qbit ? rnp_pkg::BEAT_W'(trial - {1'b0, den_r})
                     : trial[rnp_pkg::BEAT_W-1:0];
      dvd_nxt = {dvd_r[rnp_pkg::UNIT_W-2:0], qbit};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        unit_nxt = dvd_nxt;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      unit_r <= rnp_pkg::UNIT_RESET;
    end else begin
      busy_r <= busy_nxt;
      unit_r <= unit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign unit = unit_r;

endmodule

>>> rtl/core/rnp_ctrl.sv
// Parser state machine and two-stage result pipeline control.
module rnp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_stall,
  input  logic           div_busy,
  input  rnp_pkg::stat_t stat,
  output logic           in_stall,
  output logic           out_valid,
  output rnp_pkg::cmd_t  cmd
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_DIG1  = 3'd1;
  localparam logic [2:0] PH_DIG2  = 3'd2;
  localparam logic [2:0] PH_NOTE  = 3'd3;
  localparam logic [2:0] PH_SHARP = 3'd4;
  localparam logic [2:0] PH_OCT   = 3'd5;
  localparam logic [2:0] PH_DOT   = 3'd6;
  localparam logic [2:0] PH_FLUSH = 3'd7;

  logic [2:0]    phase_r, phase_nxt;
  logic          s1_valid_r, s1_valid_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    ph;
  logic          fresh;
  logic          result;
  logic          s1_adv;
  logic          stall;
  logic          acc;
  rnp_pkg::cmd_t act;

  always_comb begin
    act    = '0;
    ph     = phase_r;
    fresh  = 1'b1;
    result = 1'b0;
    s1_adv = s1_valid_r && (!out_valid_r || !out_stall);
    stall  = div_busy || (s1_valid_r && !s1_adv);
    acc    = in_valid && !stall;

    if (phase_r == PH_FLUSH) begin
      // held note from an end collision, input ignored
      act.emit     = 1'b1;
      act.emit_end = 1'b1;
      ph           = PH_IDLE;
      result       = 1'b1;
    end else begin
      if (phase_r >= PH_NOTE) begin
        fresh = 1'b0;
        if (phase_r == PH_NOTE && stat.is_sharp) begin
          act.sharpen = 1'b1;
          ph          = PH_SHARP;
        end else if (phase_r <= PH_SHARP && stat.is_oct) begin
          act.load_oct = 1'b1;
          ph           = PH_OCT;
        end else if (phase_r <= PH_OCT && stat.is_dot) begin
          act.set_dot = 1'b1;
          ph          = PH_DOT;
        end else begin
          // note ends; a non-comma is reparsed as a new start
          act.emit = 1'b1;
          ph       = PH_IDLE;
          fresh    = !stat.is_comma;
        end
      end

      if (fresh) begin
        if (ph == PH_IDLE) begin
          if (stat.is_digit) begin
            act.load_dig1 = 1'b1;
            ph            = PH_DIG1;
          end else if (stat.is_letter) begin
            act.start_note = 1'b1;
            ph             = PH_NOTE;
          end
        end else if (ph == PH_DIG1 && stat.is_digit) begin
          act.load_dig2 = 1'b1;
          ph            = PH_DIG2;
        end else if (stat.is_letter) begin
          act.start_note = 1'b1;
          act.start_keep = 1'b1;
          ph             = PH_NOTE;
        end else begin
          ph = PH_IDLE;
        end
      end

      if (stat.eot) begin
        result = 1'b1;
        if (act.emit) begin
          if (ph == PH_NOTE) begin
            ph = PH_FLUSH;
          end else begin
            act.emit_end = 1'b1;
            ph           = PH_IDLE;
          end
        end else if (ph >= PH_NOTE) begin
          act.emit     = 1'b1;
          act.emit_new = 1'b1;
          act.emit_end = 1'b1;
          ph           = PH_IDLE;
        end else begin
          act.emit_end = 1'b1;
          ph           = PH_IDLE;
        end
      end else begin
        result = act.emit;
      end
    end

    act.s1_load = result;
    cmd         = acc ? act : '0;
    cmd.out_load = s1_adv;

    phase_nxt     = acc ? ph : phase_r;
    s1_valid_nxt  = (acc && result) || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = stall;
  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/rnp_dp.sv
// Parser datapath: pending note, period lookup, length multiply, result registers.
module rnp_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [rnp_pkg::CHAR_W-1:0]     in_char_code,
  input  logic                           in_end_of_text,
  input  logic                           cfg_wr_en,
  input  logic [rnp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rnp_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  input  rnp_pkg::cmd_t                  cmd,
  input  logic [rnp_pkg::UNIT_W-1:0]     unit,
  output rnp_pkg::stat_t                 stat,
  output logic                           out_has_note,
  output logic                           out_is_rest,
  output logic [rnp_pkg::PERIOD_W-1:0]   out_period_ns,
  output logic [rnp_pkg::HIGH_W-1:0]     out_high_ns,
  output logic [rnp_pkg::LEN_W-1:0]      out_length_ms,
  output logic                           out_song_end
);

  logic [rnp_pkg::DDUR_W-1:0]   def_dur_r;
  logic [rnp_pkg::OCT_W-1:0]    def_oct_r;

  logic [rnp_pkg::NOTE_W-1:0]   note_r, note_nxt;
  logic [rnp_pkg::DUR_W-1:0]    dur_r, dur_nxt;
  logic [rnp_pkg::OCT_W-1:0]    oct_r, oct_nxt;
  logic                         dot_r, dot_nxt;

  logic [rnp_pkg::NOTE_W-1:0]   code;
  logic [3:0]                   dig_val;
  logic [rnp_pkg::DUR_W+2:0]    dur_x10;

  logic [rnp_pkg::NOTE_W-1:0]   e_note;
  logic [rnp_pkg::DUR_W-1:0]    e_dur;
  logic [rnp_pkg::OCT_W-1:0]    e_oct;
  logic                         e_dot;
  logic [rnp_pkg::DUR_W-1:0]    e_d;
  logic [rnp_pkg::UNITS_W-1:0]  e_n;
  logic [rnp_pkg::UNITS_W-1:0]  e_nd;
  logic [rnp_pkg::Q0_W-1:0]     q_sh;
  logic [rnp_pkg::Q0_W:0]       p_sum;
  logic                         e_rest;

  logic                         s1_has_r, s1_rest_r, s1_end_r;
  logic [rnp_pkg::PERIOD_W-1:0] s1_period_r;
  logic [rnp_pkg::UNITS_W-1:0]  s1_n_r;

  logic                         o_has_r, o_rest_r, o_end_r;
  logic [rnp_pkg::PERIOD_W-1:0] o_period_r;
  logic [rnp_pkg::LEN_W-1:0]    o_len_r, len_nxt;

  // character classes
  always_comb begin
    stat.is_digit  = (in_char_code >= rnp_pkg::CH_0) && (in_char_code <= rnp_pkg::CH_9);
    stat.is_oct    = (in_char_code >= rnp_pkg::CH_4) && (in_char_code <= rnp_pkg::CH_7);
    stat.is_letter = ((in_char_code >= rnp_pkg::CH_A) && (in_char_code <= rnp_pkg::CH_G))
                     || (in_char_code == rnp_pkg::CH_P);
    stat.is_sharp  = (in_char_code == rnp_pkg::CH_SHARP);
    stat.is_dot    = (in_char_code == rnp_pkg::CH_DOT);
    stat.is_comma  = (in_char_code == rnp_pkg::CH_COMMA);
    stat.eot       = in_end_of_text;
  end

  // a..g carry their code in the low nibble; digits their value
  assign code    = (in_char_code == rnp_pkg::CH_P) ? rnp_pkg::NOTE_REST : in_char_code[3:0];
  assign dig_val = in_char_code[3:0];
  assign dur_x10 = {dur_r, 3'b000} + {2'b00, dur_r, 1'b0} + {6'd0, dig_val};

  // pending note update
  always_comb begin
    note_nxt = note_r;
    dur_nxt  = dur_r;
    oct_nxt  = oct_r;
    dot_nxt  = dot_r;
    if (cmd.load_dig1) dur_nxt = {3'b000, dig_val};
    if (cmd.load_dig2) dur_nxt = dur_x10[rnp_pkg::DUR_W-1:0];
    if (cmd.start_note) begin
      note_nxt = code;
      dur_nxt  = cmd.start_keep ? dur_r : '0;
      oct_nxt  = def_oct_r;
      dot_nxt  = 1'b0;
    end
    if (cmd.sharpen)  note_nxt = rnp_pkg::sharpen(note_r);
    if (cmd.load_oct) oct_nxt  = in_char_code[rnp_pkg::OCT_W-1:0];
    if (cmd.set_dot)  dot_nxt  = 1'b1;
  end

  // note being emitted: the finished one, or the one this beat completes
  always_comb begin
    e_note = cmd.emit_new ? note_nxt : note_r;
    e_dur  = cmd.emit_new ? dur_nxt  : dur_r;
    e_oct  = cmd.emit_new ? oct_nxt  : oct_r;
    e_dot  = cmd.emit_new ? dot_nxt  : dot_r;
    e_rest = (e_note == rnp_pkg::NOTE_REST);
    e_d    = (e_dur != '0) ? e_dur : {1'b0, def_dur_r};
    e_n    = rnp_pkg::dur_units(e_d);
    e_nd   = e_dot ? (e_n + (e_n >> 1)) : e_n;
    q_sh   = rnp_pkg::note_q0(e_note) >> e_oct;
    // round half up: (q + 1) / 2
    p_sum  = {1'b0, q_sh} + {{rnp_pkg::Q0_W{1'b0}}, 1'b1};
  end

  assign len_nxt = s1_n_r * unit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_dur_r <= rnp_pkg::DEF_DUR_RESET;
      def_oct_r <= rnp_pkg::DEF_OCT_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == rnp_pkg::CFG_DEF_DUR) def_dur_r <= cfg_wr_data[rnp_pkg::DDUR_W-1:0];
      if (cfg_index == rnp_pkg::CFG_DEF_OCT) def_oct_r <= cfg_wr_data[rnp_pkg::OCT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    note_r <= note_nxt;
    dur_r  <= dur_nxt;
    oct_r  <= oct_nxt;
    dot_r  <= dot_nxt;
    if (cmd.s1_load) begin
      s1_has_r    <= cmd.emit;
      s1_rest_r   <= cmd.emit && e_rest;
      s1_end_r    <= cmd.emit_end;
      s1_period_r <= (cmd.emit && !e_rest) ? p_sum[rnp_pkg::Q0_W-1:1] : '0;
      s1_n_r      <= cmd.emit ? e_nd : '0;
    end
    if (cmd.out_load) begin
      o_has_r    <= s1_has_r;
      o_rest_r   <= s1_rest_r;
      o_end_r    <= s1_end_r;
      o_period_r <= s1_period_r;
      o_len_r    <= len_nxt;
    end
  end

  assign out_has_note  = o_has_r;
  assign out_is_rest   = o_rest_r;
  assign out_period_ns = o_period_r;
  assign out_high_ns   = o_period_r[rnp_pkg::PERIOD_W-1:1];
  assign out_length_ms = o_len_r;
  assign out_song_end  = o_end_r;

endmodule

>>> rtl/core/rtttl_note_parser.sv
// RTTTL note parser top level: controller, datapath and tempo divider.
// A result is held in stage 1, then in the output register that drives out_valid.
// Throughput, divider idle: one character per cycle while the result side keeps
//   up; parse state machine and period table lookup settle a character each cycle.
// A beat_value write starts the divider (one quotient bit per cycle);
//   input is stalled while it runs.
// Reset (rst_n low, synchronous): parser idle, pipeline empty, registers 4/6/63.
module rtttl_note_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  // character input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rnp_pkg::CHAR_W-1:0]     in_char_code,
  input  logic                           in_end_of_text,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_has_note,
  output logic                           out_is_rest,
  output logic [rnp_pkg::PERIOD_W-1:0]   out_period_ns,
  output logic [rnp_pkg::HIGH_W-1:0]     out_high_ns,
  output logic [rnp_pkg::LEN_W-1:0]      out_length_ms,
  output logic                           out_song_end,
  // configuration write port
  input  logic                           cfg_wr_en,
  input  logic [rnp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rnp_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

  // Character classes go up to the controller; the controller answers with
  // per-beat commands (digit loads, note start, sharp/octave/dot, emit) and
  // the pipeline load strobes. Stage 1 holds the looked-up period and the
  // thirty-second count; stage 2 (the output register) adds the length
  // multiply, so the next beat is taken while a result waits downstream.
  rnp_pkg::stat_t              stat;
  rnp_pkg::cmd_t               cmd;
  logic                        div_busy;
  logic [rnp_pkg::UNIT_W-1:0]  unit;

  rnp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .div_busy  (div_busy),
    .stat      (stat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  rnp_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_char_code   (in_char_code),
    .in_end_of_text (in_end_of_text),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data),
    .cmd            (cmd),
    .unit           (unit),
    .stat           (stat),
    .out_has_note   (out_has_note),
    .out_is_rest    (out_is_rest),
    .out_period_ns  (out_period_ns),
    .out_high_ns    (out_high_ns),
    .out_length_ms  (out_length_ms),
    .out_song_end   (out_song_end)
  );

  // ms per thirty-second note, recomputed on every beat_value write
  rnp_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .busy        (div_busy),
    .unit        (unit)
  );

endmodule
